// File: design/tsrr_pkg.sv
// Shared constants and types for the time-slice round-robin scheduler.
`timescale 1ns / 1ps

package tsrr_pkg;

  localparam logic [31:0] TICK_FACTOR  = 32'd3600;
  localparam logic [1:0]  SLICE_BASE   = 2'd3;
  localparam logic [15:0] RELOAD_RESET = 16'd17898;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef struct packed {
    logic found;  // an unblocked present slot was found
    logic any;    // at least one slot is present
  } pick_status_t;

endpackage

// File: design/timeslice_round_robin_scheduler.sv
// Top level of the time-slice round-robin scheduler.
`timescale 1ns / 1ps
// A taken input beat is held in the input register and then in the result register.
// Throughput: one item per cycle unless out_ready back-pressure stalls; the slot search is a
// combinational rotating priority encoder between the input register and the result register.
// Reset (synchronous, active high) clears all slots, the current process,
// the slice and the clock, and returns the tick reload to 17898.

module timeslice_round_robin_scheduler #(
  parameter int MAX_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic        voluntary,
  input  logic [3:0]  slot,
  input  logic        slot_present,
  input  logic        slot_blocked,
  input  logic [1:0]  slot_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        switched,
  output logic        current_valid,
  output logic [3:0]  current_slot,
  output logic        all_blocked,
  output logic [31:0] seconds,
  output logic [31:0] second_fraction
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // Input register.
  logic       s1_valid;
  logic       s1_action;
  logic       s1_vol;
  logic [3:0] s1_slot;
  logic       s1_present;
  logic       s1_blocked;
  logic [1:0] s1_prio;

  // Scheduler state.
  logic [MAX_SLOTS-1:0] present_mask;
  logic [MAX_SLOTS-1:0] blocked_mask;
  logic [1:0]           priority_table [MAX_SLOTS];
  logic [IDX_W-1:0]     cur_idx;
  logic                 cur_present;
  logic [1:0]           slice_left;

  logic [IDX_W-1:0]     cur_idx_next;
  logic                 cur_present_next;
  logic [1:0]           slice_left_next;
  logic                 switched_next;
  logic                 all_blocked_next;

  logic                 adv;
  logic                 fire;
  logic                 is_tick;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic [IDX_W-1:0]     pick_idx;
  tsrr_pkg::pick_status_t pick_status;
  logic [31:0]          seconds_next;
  logic [31:0]          fraction_next;

  assign adv      = !out_valid || out_ready;
  assign fire     = s1_valid && adv;
  assign in_ready = !s1_valid || adv;
  assign is_tick  = (s1_action == tsrr_pkg::ACT_TICK);
  assign slot_ok  = ({3'd0, s1_slot} < 7'(MAX_SLOTS));
  assign slot_idx = IDX_W'(s1_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action  <= action;
      s1_vol     <= voluntary;
      s1_slot    <= slot;
      s1_present <= slot_present;
      s1_blocked <= slot_blocked;
      s1_prio    <= slot_priority;
    end
  end

  tsrr_pick #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_pick (
    .present_mask (present_mask),
    .blocked_mask (blocked_mask),
    .start_valid  (cur_present),
    .start_idx    (cur_idx),
    .status       (pick_status),
    .pick_idx     (pick_idx)
  );

  tsrr_clock u_clock (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .commit        (fire),
    .advance       (is_tick && !s1_vol),
    .seconds_next  (seconds_next),
    .fraction_next (fraction_next)
  );

  always_comb begin
    cur_idx_next     = cur_idx;
    cur_present_next = cur_present;
    slice_left_next  = slice_left;
    switched_next    = 1'b0;
    all_blocked_next = 1'b0;
    if (is_tick) begin
      if (cur_present && !s1_vol && (slice_left != 2'd0)) begin
        slice_left_next = slice_left - 2'd1;
      end else if (pick_status.found) begin
        cur_idx_next     = pick_idx;
        cur_present_next = 1'b1;
        slice_left_next  = tsrr_pkg::SLICE_BASE - priority_table[pick_idx];
        switched_next    = 1'b1;
      end else if (pick_status.any) begin
        all_blocked_next = 1'b1;
      end
    end else if (slot_ok && cur_present && (cur_idx == slot_idx) && !s1_present) begin
      // Removing the running process leaves no current process.
      cur_present_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present_mask <= '0;
      blocked_mask <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        priority_table[i] <= 2'd0;
      end
      cur_idx     <= '0;
      cur_present <= 1'b0;
      slice_left  <= 2'd0;
    end else if (fire) begin
      if (!is_tick && slot_ok) begin
        present_mask[slot_idx]   <= s1_present;
        blocked_mask[slot_idx]   <= s1_blocked;
        priority_table[slot_idx] <= s1_prio;
      end
      cur_idx     <= cur_idx_next;
      cur_present <= cur_present_next;
      slice_left  <= slice_left_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      switched        <= switched_next;
      current_valid   <= cur_present_next;
      current_slot    <= cur_present_next ? 4'(cur_idx_next) : 4'd0;
      all_blocked     <= all_blocked_next;
      seconds         <= seconds_next;
      second_fraction <= fraction_next;
    end
  end

`ifndef SYNTHESIS
  a_switch_or_blocked: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(switched && all_blocked))
    else $error("switched and all_blocked reported together");

  a_switch_has_current: assert property (@(posedge clk) disable iff (rst)
    out_valid && switched |-> current_valid)
    else $error("switch reported without a current process");

  a_current_is_present: assert property (@(posedge clk) disable iff (rst)
    cur_present |-> present_mask[cur_idx])
    else $error("current process sits in an empty slot");

  a_update_no_switch: assert property (@(posedge clk) disable iff (rst)
    fire && !is_tick |=> out_valid && !switched && !all_blocked)
    else $error("slot update beat reported a switch or all-blocked");

  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !current_valid |-> current_slot == 4'd0)
    else $error("current_slot nonzero with no current process");
`endif

endmodule

// File: design/tsrr_pick.sv
// Rotating priority encoder that finds the next present, unblocked slot.
`timescale 1ns / 1ps

module tsrr_pick #(
  parameter int MAX_SLOTS = 16,
  parameter int IDX_W     = 4
) (
  input  logic [MAX_SLOTS-1:0] present_mask,
  input  logic [MAX_SLOTS-1:0] blocked_mask,
  input  logic                 start_valid,
  input  logic [IDX_W-1:0]     start_idx,
  output tsrr_pkg::pick_status_t status,
  output logic [IDX_W-1:0]     pick_idx
);

  logic [MAX_SLOTS-1:0] eligible;
  logic [MAX_SLOTS-1:0] upper;
  logic [IDX_W-1:0]     upper_idx;
  logic [IDX_W-1:0]     wrap_idx;

  assign eligible = present_mask & ~blocked_mask;

  // Slots after the start point; with no current process nothing is above,
  // so the search begins at slot 0.
  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      upper[i] = eligible[i] && start_valid && (i > int'(start_idx));
    end
  end

  always_comb begin
    upper_idx = '0;
    wrap_idx  = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        upper_idx = IDX_W'(i);
      end
      if (eligible[i]) begin
        wrap_idx = IDX_W'(i);
      end
    end
  end

  assign pick_idx     = (|upper) ? upper_idx : wrap_idx;
  assign status.found = |eligible;
  assign status.any   = |present_mask;

endmodule

// File: design/tsrr_clock.sv
// Seconds clock: binary fraction of a second plus a whole-second count.
`timescale 1ns / 1ps

module tsrr_clock (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        commit,
  input  logic        advance,
  output logic [31:0] seconds_next,
  output logic [31:0] fraction_next
);

  logic [31:0] tick_add;
  logic [31:0] seconds_count;
  logic [31:0] fraction_count;
  logic [32:0] sum;

  // The per-tick increment is formed when the reload is written, so the
  // tick path holds only the adder.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_add <= 32'(tsrr_pkg::TICK_FACTOR * {16'd0, tsrr_pkg::RELOAD_RESET});
    end else if (cfg_we) begin
      tick_add <= 32'(tsrr_pkg::TICK_FACTOR * {16'd0, cfg_wdata});
    end
  end

  assign sum = {1'b0, fraction_count} + {1'b0, tick_add};

  always_comb begin
    seconds_next  = seconds_count;
    fraction_next = fraction_count;
    if (advance) begin
      fraction_next = sum[31:0];
      seconds_next  = seconds_count + {31'd0, sum[32]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds_count  <= '0;
      fraction_count <= '0;
    end else if (commit) begin
      seconds_count  <= seconds_next;
      fraction_count <= fraction_next;
    end
  end

endmodule

// File: dv/tsrr_tb_pkg.sv
// Beat types and the scoreboard that predicts and checks scheduler results.
`timescale 1ns / 1ps

package tsrr_tb_pkg;

  localparam int SLOT_COUNT = 16;

  typedef struct packed {
    logic       action;
    logic       voluntary;
    logic [3:0] slot;
    logic       slot_present;
    logic       slot_blocked;
    logic [1:0] slot_priority;
  } sched_req_t;

  typedef struct packed {
    logic        switched;
    logic        current_valid;
    logic [3:0]  current_slot;
    logic        all_blocked;
    logic [31:0] seconds;
    logic [31:0] second_fraction;
  } sched_view_t;

  class sched_scoreboard;
    logic [15:0] reload;
    logic [15:0] present_bits;
    logic [15:0] blocked_bits;
    logic [1:0]  prio [SLOT_COUNT];
    logic [3:0]  cur_slot;
    logic        cur_valid;
    logic [1:0]  slice_left;
    logic [31:0] secs;
    logic [31:0] frac;

    sched_view_t predicted_views[$];
    int fail_count;
    int req_beats;
    int view_beats;
    int switch_count;
    int all_blocked_count;

    function new();
      reload       = tsrr_pkg::RELOAD_RESET;
      present_bits = '0;
      blocked_bits = '0;
      foreach (prio[i]) prio[i] = '0;
      cur_slot     = '0;
      cur_valid    = 1'b0;
      slice_left   = '0;
      secs         = '0;
      frac         = '0;
      fail_count   = 0;
      req_beats    = 0;
      view_beats   = 0;
      switch_count = 0;
      all_blocked_count = 0;
    endfunction

    // Applies one accepted request beat to the model state and queues the view it causes.
    function void note_input(sched_req_t req);
      sched_view_t view;
      logic [31:0] add;
      logic [32:0] sum;
      logic [3:0]  start;
      logic [3:0]  idx;
      logic        need;
      logic        any;
      logic        found;
      view = '0;
      req_beats++;
      if (req.action == tsrr_pkg::ACT_UPDATE) begin
        present_bits[req.slot] = req.slot_present;
        blocked_bits[req.slot] = req.slot_blocked;
        prio[req.slot] = req.slot_priority;
        if (cur_valid && cur_slot == req.slot && !req.slot_present) cur_valid = 1'b0;
      end else begin
        if (!req.voluntary) begin
          add  = tsrr_pkg::TICK_FACTOR * {16'd0, reload};
          sum  = {1'b0, frac} + {1'b0, add};
          if (sum[32]) secs = secs + 32'd1;
          frac = sum[31:0];
        end
        need = 1'b1;
        if (cur_valid && !req.voluntary && slice_left != 2'd0) begin
          slice_left = slice_left - 2'd1;
          need = 1'b0;
        end
        if (need) begin
          // With no current process the search wraps around to begin at slot 0.
          start = cur_valid ? cur_slot : 4'(SLOT_COUNT - 1);
          any   = 1'b0;
          found = 1'b0;
          for (int k = 1; k <= SLOT_COUNT; k++) begin
            idx = start + 4'(k);
            if (!found && present_bits[idx]) begin
              any = 1'b1;
              if (!blocked_bits[idx]) begin
                found      = 1'b1;
                cur_slot   = idx;
                cur_valid  = 1'b1;
                slice_left = tsrr_pkg::SLICE_BASE - prio[idx];
              end
            end
          end
          view.switched    = found;
          view.all_blocked = any && !found;
        end
      end
      view.current_valid   = cur_valid;
      view.current_slot    = cur_valid ? cur_slot : 4'd0;
      view.seconds         = secs;
      view.second_fraction = frac;
      if (view.switched) switch_count++;
      if (view.all_blocked) all_blocked_count++;
      predicted_views.push_back(view);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(sched_view_t got);
      sched_view_t want;
      view_beats++;
      if (predicted_views.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        fail_count++;
        return;
      end
      want = predicted_views.pop_front();
      compare_field("switched", 32'(want.switched), 32'(got.switched));
      compare_field("current_valid", 32'(want.current_valid), 32'(got.current_valid));
      compare_field("current_slot", 32'(want.current_slot), 32'(got.current_slot));
      compare_field("all_blocked", 32'(want.all_blocked), 32'(got.all_blocked));
      compare_field("seconds", want.seconds, got.seconds);
      compare_field("second_fraction", want.second_fraction, got.second_fraction);
    endfunction
  endclass

endpackage

// File: dv/timeslice_round_robin_scheduler_tb.sv
// Self-checking testbench for the time-slice round-robin scheduler.
`timescale 1ns / 1ps

module timeslice_round_robin_scheduler_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_BEATS    = 292;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action = 1'b0;
  logic        voluntary = 1'b0;
  logic [3:0]  slot = '0;
  logic        slot_present = 1'b0;
  logic        slot_blocked = 1'b0;
  logic [1:0]  slot_priority = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        switched;
  logic        current_valid;
  logic [3:0]  current_slot;
  logic        all_blocked;
  logic [31:0] seconds;
  logic [31:0] second_fraction;

  tsrr_tb_pkg::sched_scoreboard sb;
  int send_idle_pct = 29;
  int recv_idle_pct = 48;
  int quiet_cycles  = 0;

  timeslice_round_robin_scheduler #(.MAX_SLOTS(tsrr_tb_pkg::SLOT_COUNT)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .voluntary(voluntary), .slot(slot),
    .slot_present(slot_present), .slot_blocked(slot_blocked),
    .slot_priority(slot_priority),
    .out_valid(out_valid), .out_ready(out_ready),
    .switched(switched), .current_valid(current_valid), .current_slot(current_slot),
    .all_blocked(all_blocked), .seconds(seconds), .second_fraction(second_fraction)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_monitor
    tsrr_tb_pkg::sched_view_t got;
    if (!rst && out_valid && out_ready) begin
      got.switched        = switched;
      got.current_valid   = current_valid;
      got.current_slot    = current_slot;
      got.all_blocked     = all_blocked;
      got.seconds         = seconds;
      got.second_fraction = second_fraction;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic tsrr_tb_pkg::sched_req_t make_req(logic act, logic vol, logic [3:0] idx,
                                                       logic pres, logic blk, logic [1:0] pri);
    tsrr_tb_pkg::sched_req_t req;
    req.action        = act;
    req.voluntary     = vol;
    req.slot          = idx;
    req.slot_present  = pres;
    req.slot_blocked  = blk;
    req.slot_priority = pri;
    return req;
  endfunction

  function automatic tsrr_tb_pkg::sched_req_t random_req(int block_pct);
    tsrr_tb_pkg::sched_req_t req;
    req = tsrr_tb_pkg::sched_req_t'(10'($urandom));
    if ($urandom_range(99) < 40) begin
      req.action = tsrr_pkg::ACT_UPDATE;
      // Half the updates land on a few slots so that those slots churn.
      if ($urandom_range(1)) req.slot = 4'($urandom_range(3));
      req.slot_present = ($urandom_range(99) < 70);
      req.slot_blocked = ($urandom_range(99) < block_pct);
    end else begin
      req.action    = tsrr_pkg::ACT_TICK;
      req.voluntary = ($urandom_range(99) < 25);
    end
    return req;
  endfunction

  // Called at a clock edge; returns at the edge where the beat was taken, valid still high.
  task automatic drive_item(tsrr_tb_pkg::sched_req_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= req.action;
    voluntary     <= req.voluntary;
    slot          <= req.slot;
    slot_present  <= req.slot_present;
    slot_blocked  <= req.slot_blocked;
    slot_priority <= req.slot_priority;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req);
  endtask

  task automatic drain_results(int extra);
    while (sb.predicted_views.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    logic [15:0] reload;
    int block_pct;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the reset reload value.
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0)); // nothing present
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b1, 4'd0, 1'b0, 1'b0, 2'd0)); // voluntary, no time
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd0, 1'b1, 1'b0, 2'd3));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0)); // search from slot 0
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0)); // same slot again
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b1, 4'd15, 1'b1, 1'b0, 2'd0)); // voluntary ignored
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b1, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0)); // slice ran out
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd0, 1'b1, 1'b1, 2'd2));
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd15, 1'b1, 1'b1, 2'd1));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b1, 4'd0, 1'b0, 1'b0, 2'd0)); // all blocked
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0)); // remove current
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd15, 1'b0, 1'b1, 2'd3));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd5, 1'b1, 1'b0, 2'd1));
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b1, 4'd10, 1'b1, 1'b0, 2'd2));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b1, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b0, 4'd0, 1'b0, 1'b0, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_UPDATE, 1'b0, 4'd10, 1'b1, 1'b1, 2'd0));
    drive_item(make_req(tsrr_pkg::ACT_TICK, 1'b1, 4'd0, 1'b0, 1'b0, 2'd0));

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      in_valid <= 1'b0;
      drain_results(3);
      case (ph)
        0:       reload = 16'd1;
        1:       reload = 16'hFFFF;
        3:       reload = tsrr_pkg::RELOAD_RESET;
        5:       reload = 16'hFFFF;
        default: reload = 16'($urandom_range(65535, 1));
      endcase
      cfg_we    <= 1'b1;
      cfg_wdata <= reload;
      @(posedge clk);
      cfg_we <= 1'b0;
      sb.reload = reload;

      // Handshake profile changes every second phase.
      case (ph / 2)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      block_pct = (ph % 2 == 1) ? 75 : 20;
      repeat (PHASE_BEATS) drive_item(random_req(block_pct));
    end

    in_valid <= 1'b0;
    drain_results(8);

    $display("Ran %0d request beats and checked %0d result beats over %0d reload settings.",
             sb.req_beats, sb.view_beats, PHASE_COUNT + 1);
    $display("Predicted %0d switches and %0d all-blocked outcomes.",
             sb.switch_count, sb.all_blocked_count);
    if (sb.fail_count == 0 && sb.predicted_views.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/tsrr_pkg.sv
design/tsrr_pick.sv
design/tsrr_clock.sv
design/timeslice_round_robin_scheduler.sv
dv/tsrr_tb_pkg.sv
dv/timeslice_round_robin_scheduler_tb.sv
